FILE: rtl/dpec_pkg.sv
// Shared types and constants for the depth patch edge classifier.
// Depends on nothing; every rtl file refers to it by scoped names.
package dpec_pkg;

   localparam int DEPTH_BITS     = 16;
   localparam int SAMPLES        = 9;
   localparam int IDX_W          = 4;
   localparam int SUM_W          = DEPTH_BITS + 4;
   localparam int DEV_W          = SUM_W;
   localparam int SQ_W           = 2 * DEV_W;
   localparam int WSUM_W         = SQ_W + 4;
   localparam int AD_W           = WSUM_W;
   localparam int SCORE_W        = AD_W + 4;
   localparam int THR_W          = 32;
   localparam int SCALE_W        = 13;
   localparam int THR_SCALED_W   = THR_W + SCALE_W;
   localparam int CMP_W          = (SCORE_W > THR_SCALED_W) ? SCORE_W : THR_SCALED_W;

   localparam logic [IDX_W-1:0]   CENTER_INDEX = IDX_W'(4);
   localparam logic [IDX_W-1:0]   LAST_INDEX   = IDX_W'(SAMPLES - 1);
   localparam logic [SCALE_W-1:0] SCORE_SCALE  = SCALE_W'(6561);

   typedef logic [DEPTH_BITS-1:0] depth_type;

   typedef struct packed {
      depth_type depth_top_left;
      depth_type depth_top_mid;
      depth_type depth_top_right;
      depth_type depth_mid_left;
      depth_type depth_center;
      depth_type depth_mid_right;
      depth_type depth_bottom_left;
      depth_type depth_bottom_mid;
      depth_type depth_bottom_right;
   } req_type;

   typedef struct packed {
      logic             is_strong;
      logic [IDX_W-1:0] nearest_index;
   } rsp_type;

endpackage

FILE: rtl/depth_patch_edge_classifier.sv
// Top level of the depth patch edge classifier: nine sample lanes,
// adder trees, nearest search and the threshold compare.
// Depends on dpec_pkg, dpec_sum9, dpec_lane and dpec_nearest.
//
// Usage:
//   A request (nine depth samples in req_data) is taken at every rising
//   edge where start is high; busy is always low, so a request can be
//   issued every cycle and the block sustains one request per cycle.
//   Each request yields one result on rsp_data, shown for exactly one
//   cycle with rsp_strobe high. The input register loads at the request
//   edge; then sample sum tree (2), deviation and square in the lanes (2),
//   squared deviation sum tree (2), lane spread term (1), score sum tree
//   (2) and the registered compare (1), which drives rsp_data.
//   Results leave in request order. The receiver cannot stall the block.
//   csr_we writes csr_wdata into the threshold register; write it only
//   while no request is in flight. The compare uses its registered scaled copy.
//   Synchronous reset clears the pipeline valids (no result appears for
//   a request taken before reset) and sets the threshold to 0.
module depth_patch_edge_classifier (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  dpec_pkg::req_type          req_data,
   output logic                       rsp_strobe,
   output dpec_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  logic [dpec_pkg::THR_W-1:0] csr_wdata
);

   localparam int LAST_STAGE = 10;
   localparam int IDX_DLY    = 7;

   logic [LAST_STAGE:0]                    v_in;
   logic [LAST_STAGE:0]                    v_ff;
   logic [dpec_pkg::DEPTH_BITS-1:0]        d_in    [dpec_pkg::SAMPLES];
   logic [dpec_pkg::DEPTH_BITS-1:0]        d_ff    [dpec_pkg::SAMPLES];
   logic [dpec_pkg::DEPTH_BITS-1:0]        d_s1_ff [dpec_pkg::SAMPLES];
   logic [dpec_pkg::DEPTH_BITS-1:0]        d_s2_ff [dpec_pkg::SAMPLES];
   logic [dpec_pkg::SUM_W-1:0]             sum;
   logic [dpec_pkg::SQ_W-1:0]              sq_dev  [dpec_pkg::SAMPLES];
   logic [dpec_pkg::WSUM_W-1:0]            wsum;
   logic [dpec_pkg::AD_W-1:0]              abs_diff [dpec_pkg::SAMPLES];
   logic [dpec_pkg::SCORE_W-1:0]           score;
   logic [dpec_pkg::IDX_W-1:0]             nearest;
   logic [dpec_pkg::IDX_W-1:0]             idx_dly_ff [IDX_DLY];
   logic [dpec_pkg::THR_W-1:0]             thr_in;
   logic [dpec_pkg::THR_W-1:0]             thr_ff;
   logic [dpec_pkg::THR_SCALED_W-1:0]      thr_scaled_in;
   logic [dpec_pkg::THR_SCALED_W-1:0]      thr_scaled_ff;
   dpec_pkg::rsp_type                      rsp_in;
   dpec_pkg::rsp_type                      rsp_ff;

   assign busy = 1'b0;

   always_comb begin
      d_in[0] = req_data.depth_top_left;
      d_in[1] = req_data.depth_top_mid;
      d_in[2] = req_data.depth_top_right;
      d_in[3] = req_data.depth_mid_left;
      d_in[4] = req_data.depth_center;
      d_in[5] = req_data.depth_mid_right;
      d_in[6] = req_data.depth_bottom_left;
      d_in[7] = req_data.depth_bottom_mid;
      d_in[8] = req_data.depth_bottom_right;

      v_in = {v_ff[LAST_STAGE-1:0], start && !busy};

      thr_in        = csr_we ? csr_wdata : thr_ff;
      thr_scaled_in = thr_ff * dpec_pkg::SCORE_SCALE;

      rsp_in.is_strong     = dpec_pkg::CMP_W'(score) > dpec_pkg::CMP_W'(thr_scaled_ff);
      rsp_in.nearest_index = idx_dly_ff[IDX_DLY-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff          <= '0;
         thr_ff        <= '0;
         thr_scaled_ff <= '0;
      end else begin
         v_ff          <= v_in;
         thr_ff        <= thr_in;
         thr_scaled_ff <= thr_scaled_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff          <= d_in;
      d_s1_ff       <= d_ff;
      d_s2_ff       <= d_s1_ff;
      idx_dly_ff[0] <= nearest;
      for (int i = 1; i < IDX_DLY; i++) begin
         idx_dly_ff[i] <= idx_dly_ff[i-1];
      end
      rsp_ff        <= rsp_in;
   end

   dpec_sum9 #(
      .IN_W  (dpec_pkg::DEPTH_BITS),
      .OUT_W (dpec_pkg::SUM_W)
   ) u_sum_depth (
      .clock (clock),
      .din   (d_ff),
      .sum   (sum)
   );

   dpec_nearest u_nearest (
      .clock   (clock),
      .depth   (d_ff),
      .nearest (nearest)
   );

   for (genvar g = 0; g < dpec_pkg::SAMPLES; g++) begin : g_lane
      dpec_lane u_lane (
         .clock    (clock),
         .depth    (d_s2_ff[g]),
         .sum      (sum),
         .wsum     (wsum),
         .sq_dev   (sq_dev[g]),
         .abs_diff (abs_diff[g])
      );
   end

   dpec_sum9 #(
      .IN_W  (dpec_pkg::SQ_W),
      .OUT_W (dpec_pkg::WSUM_W)
   ) u_sum_sq (
      .clock (clock),
      .din   (sq_dev),
      .sum   (wsum)
   );

   dpec_sum9 #(
      .IN_W  (dpec_pkg::AD_W),
      .OUT_W (dpec_pkg::SCORE_W)
   ) u_sum_score (
      .clock (clock),
      .din   (abs_diff),
      .sum   (score)
   );

   assign rsp_strobe = v_ff[LAST_STAGE];
   assign rsp_data   = rsp_ff;

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] |-> ##LAST_STAGE rsp_strobe)
      else $error("request produced no result");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(v_ff[LAST_STAGE-1]))
      else $error("result without a request");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.nearest_index <= dpec_pkg::LAST_INDEX))
      else $error("nearest index out of range");

endmodule

FILE: rtl/dpec_sum9.sv
// Two-stage registered adder tree over nine unsigned operands.
// Depends on dpec_pkg for the operand count.
module dpec_sum9 #(
   parameter int IN_W  = dpec_pkg::DEPTH_BITS,
   parameter int OUT_W = dpec_pkg::SUM_W
) (
   input  logic             clock,
   input  logic [IN_W-1:0]  din [dpec_pkg::SAMPLES],
   output logic [OUT_W-1:0] sum
);

   localparam int PART_W = IN_W + 2;

   logic [PART_W-1:0] part_in [3];
   logic [PART_W-1:0] part_ff [3];
   logic [OUT_W-1:0]  sum_in;
   logic [OUT_W-1:0]  sum_ff;

   always_comb begin
      for (int g = 0; g < 3; g++) begin
         part_in[g] = PART_W'(din[3*g]) + PART_W'(din[3*g+1]) + PART_W'(din[3*g+2]);
      end
      sum_in = OUT_W'(part_ff[0]) + OUT_W'(part_ff[1]) + OUT_W'(part_ff[2]);
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      sum_ff  <= sum_in;
   end

   assign sum = sum_ff;

endmodule

FILE: rtl/dpec_lane.sv
// One sample lane: squared deviation from the mean and its spread term.
// Depends on dpec_pkg for widths.
module dpec_lane (
   input  logic                         clock,
   input  logic [dpec_pkg::DEPTH_BITS-1:0] depth,
   input  logic [dpec_pkg::SUM_W-1:0]   sum,
   input  logic [dpec_pkg::WSUM_W-1:0]  wsum,
   output logic [dpec_pkg::SQ_W-1:0]    sq_dev,
   output logic [dpec_pkg::AD_W-1:0]    abs_diff
);

   logic [dpec_pkg::SUM_W-1:0]  nine_d;
   logic [dpec_pkg::DEV_W-1:0]  dev_in;
   logic [dpec_pkg::DEV_W-1:0]  dev_ff;
   logic [dpec_pkg::SQ_W-1:0]   sq_in;
   logic [dpec_pkg::SQ_W-1:0]   sq_ff;
   logic [dpec_pkg::SQ_W-1:0]   sq_d1_ff;
   logic [dpec_pkg::SQ_W-1:0]   sq_d2_ff;
   logic [dpec_pkg::AD_W-1:0]   nine_w;
   logic [dpec_pkg::AD_W-1:0]   ad_in;
   logic [dpec_pkg::AD_W-1:0]   ad_ff;

   always_comb begin
      nine_d = (dpec_pkg::SUM_W'(depth) << 3) + dpec_pkg::SUM_W'(depth);
      dev_in = (nine_d >= sum) ? (nine_d - sum) : (sum - nine_d);
      sq_in  = dev_ff * dev_ff;
      nine_w = (dpec_pkg::AD_W'(sq_d2_ff) << 3) + dpec_pkg::AD_W'(sq_d2_ff);
      ad_in  = (nine_w >= wsum) ? (nine_w - wsum) : (wsum - nine_w);
   end

   // sq_d2_ff lines up with wsum from the shared adder tree
   always_ff @(posedge clock) begin
      dev_ff   <= dev_in;
      sq_ff    <= sq_in;
      sq_d1_ff <= sq_ff;
      sq_d2_ff <= sq_d1_ff;
      ad_ff    <= ad_in;
   end

   assign sq_dev   = sq_ff;
   assign abs_diff = ad_ff;

endmodule

FILE: rtl/dpec_nearest.sv
// Nearest nonzero depth search, two registered compare levels.
// Depends on dpec_pkg for widths and the centre index.
module dpec_nearest (
   input  logic                            clock,
   input  logic [dpec_pkg::DEPTH_BITS-1:0] depth [dpec_pkg::SAMPLES],
   output logic [dpec_pkg::IDX_W-1:0]      nearest
);

   typedef struct packed {
      logic                            found;
      logic [dpec_pkg::DEPTH_BITS-1:0] depth;
      logic [dpec_pkg::IDX_W-1:0]      idx;
   } cand_type;

   // lower index wins on a tie
   function automatic cand_type pick(cand_type a, cand_type b);
      return (b.found && (!a.found || (b.depth < a.depth))) ? b : a;
   endfunction

   cand_type                        leaf     [dpec_pkg::SAMPLES];
   cand_type                        group_in [3];
   cand_type                        group_ff [3];
   logic [dpec_pkg::DEPTH_BITS-1:0] center_ff;
   cand_type                        best;
   logic [dpec_pkg::IDX_W-1:0]      nearest_in;
   logic [dpec_pkg::IDX_W-1:0]      nearest_ff;

   always_comb begin
      for (int i = 0; i < dpec_pkg::SAMPLES; i++) begin
         leaf[i].found = (depth[i] != '0);
         leaf[i].depth = depth[i];
         leaf[i].idx   = dpec_pkg::IDX_W'(i);
      end
      for (int g = 0; g < 3; g++) begin
         group_in[g] = pick(pick(leaf[3*g], leaf[3*g+1]), leaf[3*g+2]);
      end
      best = pick(pick(group_ff[0], group_ff[1]), group_ff[2]);
      if ((center_ff != '0) && best.found && (best.depth < center_ff)) begin
         nearest_in = best.idx;
      end else begin
         nearest_in = dpec_pkg::CENTER_INDEX;
      end
   end

   always_ff @(posedge clock) begin
      group_ff   <= group_in;
      center_ff  <= depth[dpec_pkg::CENTER_INDEX];
      nearest_ff <= nearest_in;
   end

   assign nearest = nearest_ff;

endmodule

FILE: tb/sv/tb_depth_patch_edge_classifier.sv
// Self-checking testbench for depth_patch_edge_classifier: directed and random
// patches against an integer predictor, checked by a small scoreboard class.
// Depends on dpec_pkg and the depth_patch_edge_classifier RTL.
module tb_depth_patch_edge_classifier;
   timeunit 1ns;
   timeprecision 1ps;

   import dpec_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_ITEMS  = 90;

   typedef logic [DEPTH_BITS-1:0] patch_array_t [SAMPLES];

   class patch_mark_board;
      rsp_type expected_marks[$];
      int      error_count;

      function new();
         error_count = 0;
      endfunction

      function rsp_type classify_patch(req_type p, logic [THR_W-1:0] thr);
         logic [63:0] d [SAMPLES];
         logic [63:0] w [SAMPLES];
         logic [63:0] dsum;
         logic [63:0] wsum;
         logic [63:0] score;
         logic [63:0] dev;
         logic [63:0] t9;
         logic [IDX_W-1:0] k;
         rsp_type res;
         d[0] = p.depth_top_left;
         d[1] = p.depth_top_mid;
         d[2] = p.depth_top_right;
         d[3] = p.depth_mid_left;
         d[4] = p.depth_center;
         d[5] = p.depth_mid_right;
         d[6] = p.depth_bottom_left;
         d[7] = p.depth_bottom_mid;
         d[8] = p.depth_bottom_right;
         dsum = '0;
         k = CENTER_INDEX;
         for (int i = 0; i < SAMPLES; i++) begin
            dsum += d[i];
            if (d[i] != 0 && d[i] < d[k]) begin
               k = IDX_W'(i);
            end
         end
         wsum = '0;
         for (int i = 0; i < SAMPLES; i++) begin
            t9 = 64'd9 * d[i];
            dev = (t9 >= dsum) ? t9 - dsum : dsum - t9;
            w[i] = dev * dev;
            wsum += w[i];
         end
         score = '0;
         for (int i = 0; i < SAMPLES; i++) begin
            t9 = 64'd9 * w[i];
            score += (t9 >= wsum) ? t9 - wsum : wsum - t9;
         end
         res.is_strong     = (score > 64'd6561 * 64'(thr));
         res.nearest_index = k;
         return res;
      endfunction

      function void note_patch(req_type p, logic [THR_W-1:0] thr);
         expected_marks.push_back(classify_patch(p, thr));
      endfunction

      function void check_mark(rsp_type got);
         rsp_type exp_mark;
         if (expected_marks.size() == 0) begin
            $display("%0t: unexpected result is_strong=%0d nearest_index=%0d",
                     $time, got.is_strong, got.nearest_index);
            error_count++;
         end else begin
            exp_mark = expected_marks.pop_front();
            if (got.is_strong !== exp_mark.is_strong) begin
               $display("%0t: is_strong expected %0d actual %0d",
                        $time, exp_mark.is_strong, got.is_strong);
               error_count++;
            end
            if (got.nearest_index !== exp_mark.nearest_index) begin
               $display("%0t: nearest_index expected %0d actual %0d",
                        $time, exp_mark.nearest_index, got.nearest_index);
               error_count++;
            end
         end
      endfunction

      function int pending();
         return expected_marks.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_strobe;
   rsp_type           rsp_data;
   logic              csr_we;
   logic [THR_W-1:0]  csr_wdata;

   logic [THR_W-1:0]  threshold_model;
   patch_mark_board   board;
   int                cycle_count;

   depth_patch_edge_classifier i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            board.note_patch(req_data, threshold_model);
         end
         if (rsp_strobe) begin
            board.check_mark(rsp_data);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   function automatic req_type pack_patch(patch_array_t d);
      req_type p;
      p.depth_top_left     = d[0];
      p.depth_top_mid      = d[1];
      p.depth_top_right    = d[2];
      p.depth_mid_left     = d[3];
      p.depth_center       = d[4];
      p.depth_mid_right    = d[5];
      p.depth_bottom_left  = d[6];
      p.depth_bottom_mid   = d[7];
      p.depth_bottom_right = d[8];
      return p;
   endfunction

   function automatic patch_array_t fill_patch(int unsigned v);
      patch_array_t d;
      foreach (d[i]) d[i] = DEPTH_BITS'(v);
      return d;
   endfunction

   function automatic req_type random_patch();
      patch_array_t d;
      int           mode;
      int           base;
      int           spread;
      int           v;
      mode = $urandom_range(0, 5);
      base = $urandom_range(0, 65535);
      spread = 1 << $urandom_range(0, 12);
      foreach (d[i]) begin
         case (mode)
            0: begin
               d[i] = DEPTH_BITS'($urandom());
            end
            1, 2: begin
               v = base + $urandom_range(0, 2 * spread) - spread;
               if (v < 0) v = 0;
               if (v > 65535) v = 65535;
               d[i] = DEPTH_BITS'(v);
               if (mode == 2 && $urandom_range(0, 99) < 30) d[i] = '0;
            end
            3: begin
               d[i] = DEPTH_BITS'(base);
            end
            4: begin
               case ($urandom_range(0, 3))
                  0: d[i] = '0;
                  1: d[i] = DEPTH_BITS'(1);
                  2: d[i] = DEPTH_BITS'(65534);
                  default: d[i] = '1;
               endcase
            end
            default: begin
               d[i] = ((i % 3) < 1 + (mode & 1)) ? DEPTH_BITS'(base)
                                                 : DEPTH_BITS'(base + spread);
            end
         endcase
      end
      if (mode == 3 && $urandom_range(0, 1)) begin
         d[$urandom_range(0, SAMPLES - 1)] = DEPTH_BITS'(base + spread);
      end
      return pack_patch(d);
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_patch(req_type p, int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(negedge clock);
      while (board.pending() > 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] value);
      csr_we          <= 1'b1;
      csr_wdata       <= value;
      threshold_model  = value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_directed();
      patch_array_t d;
      send_patch(pack_patch(fill_patch(0)), 0);
      send_patch(pack_patch(fill_patch(65535)), 0);
      send_patch(pack_patch(fill_patch(1000)), 0);
      d = fill_patch(1000);
      d[7] = DEPTH_BITS'(1001);
      send_patch(pack_patch(d), 0);
      d = fill_patch(0);
      d[4] = '1;
      send_patch(pack_patch(d), 0);
      // zero centre keeps the centre index
      d = fill_patch(5);
      d[4] = '0;
      send_patch(pack_patch(d), 0);
      d = fill_patch(65535);
      d[0] = DEPTH_BITS'(1);
      send_patch(pack_patch(d), 0);
      d = fill_patch(65535);
      d[8] = DEPTH_BITS'(1);
      send_patch(pack_patch(d), 0);
      // equal minima: the first one wins
      d = fill_patch(100);
      d[0] = DEPTH_BITS'(10);
      d[8] = DEPTH_BITS'(10);
      send_patch(pack_patch(d), 0);
      d = fill_patch(100);
      d[2] = DEPTH_BITS'(10);
      d[6] = DEPTH_BITS'(10);
      send_patch(pack_patch(d), 0);
      foreach (d[i]) d[i] = (i % 2) ? '1 : '0;
      send_patch(pack_patch(d), 0);
      foreach (d[i]) d[i] = (i % 2) ? '0 : '1;
      send_patch(pack_patch(d), 0);
      foreach (d[i]) d[i] = (i % 2) ? DEPTH_BITS'(16'h5555) : DEPTH_BITS'(16'haaaa);
      send_patch(pack_patch(d), 0);
      foreach (d[i]) d[i] = DEPTH_BITS'(i + 1);
      send_patch(pack_patch(d), 0);
      foreach (d[i]) d[i] = DEPTH_BITS'(SAMPLES - i);
      send_patch(pack_patch(d), 0);
      d = fill_patch(800);
      d[4] = DEPTH_BITS'(500);
      d[3] = '0;
      d[5] = DEPTH_BITS'(200);
      send_patch(pack_patch(d), 0);
      d = fill_patch(65535);
      d[4] = DEPTH_BITS'(1);
      send_patch(pack_patch(d), 0);
      d = fill_patch(65534);
      d[1] = '0;
      d[6] = '1;
      send_patch(pack_patch(d), 0);
   endtask

   task automatic run_phase(logic [THR_W-1:0] thr, int idle_pct, bit hold_mid);
      drain_results();
      write_threshold(thr);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (hold_mid && i == PHASE_ITEMS / 2) begin
            start <= 1'b0;
            @(negedge clock);
            while (board.pending() > 0) @(negedge clock);
         end
         send_patch(random_patch(), ((i / 16) % 3 == 0) ? 0 : idle_pct);
      end
   endtask

   initial begin
      board           = new();
      threshold_model = '0;
      reset           = 1'b1;
      start           = 1'b0;
      req_data        = '0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      run_phase('1, 0, 1'b0);
      run_phase(THR_W'($urandom_range(0, 4095)), 63, 1'b1);
      run_phase(THR_W'($urandom() >> $urandom_range(0, 31)), 28, 1'b0);
      run_phase(THR_W'(1), 0, 1'b0);
      run_phase(THR_W'($urandom_range(0, 1 << 24)), 63, 1'b0);
      drain_results();

      if (board.error_count == 0 && board.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/dpec_pkg.sv
rtl/dpec_sum9.sv
rtl/dpec_lane.sv
rtl/dpec_nearest.sv
rtl/depth_patch_edge_classifier.sv
tb/sv/tb_depth_patch_edge_classifier.sv
